// ===== rtl/core/led_trail_fade_renderer_assert.svh =====
// Assertion macros for the LED trail fade renderer.
`ifndef LED_TRAIL_FADE_RENDERER_ASSERT_SVH
`define LED_TRAIL_FADE_RENDERER_ASSERT_SVH

// Check that a condition implies another at the same clock edge.
`define LTFR_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ltfr assertion failed");

// Check that a condition implies another at the following clock edge.
`define LTFR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ltfr assertion failed");

`endif

// ===== rtl/core/ltfr_pkg.sv =====
// Shared types, codes and constants of the LED trail fade renderer.
package ltfr_pkg;

   // Request type codes
   localparam logic ReqRender = 1'b0;
   localparam logic ReqClear  = 1'b1;

   // Bright channel codes
   localparam logic [1:0] ColorGreen = 2'd0;
   localparam logic [1:0] ColorRed   = 2'd1;
   localparam logic [1:0] ColorBlue  = 2'd2;
   localparam logic [1:0] ColorReset = ColorRed;

   // Brightness levels
   localparam int         LevelTrailTop = 200;
   localparam logic [7:0] LevelDot      = 8'd255;
   localparam int         DimShift      = 3;

   // Output register occupancy
   typedef enum logic {
      StEmpty,
      StFull
   } state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load_result;
      logic push_trail;
      logic clear_trail;
   } cmd_type;

   // Level of trail slot 'slot' for a per-slot fade of 'step', floored at zero.
   function automatic logic [7:0] trail_slot_level(input int slot, input int step);
      int prod;
      prod = slot * step;
      return (prod >= LevelTrailTop) ? 8'd0 : 8'(LevelTrailTop - prod);
   endfunction

endpackage

// ===== rtl/core/led_trail_fade_renderer.sv =====
// Top level of the LED trail fade renderer: controller plus datapath.
// Latency: a render transaction's result is valid the cycle after it is accepted.
// Throughput: one transaction per cycle while rsp_ready holds; a single output
// register decouples the channels, and all TRAIL_DEPTH slot comparators work in
// parallel. Clear transactions return no result. Reset empties the history, sets the
// color mode to red and leaves the output register empty.
`include "led_trail_fade_renderer_assert.svh"

module led_trail_fade_renderer #(
   parameter int TRAIL_DEPTH = 12
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_type,
   input  logic [7:0] req_pixel_index,
   input  logic [7:0] req_dot_index,
   input  logic       req_end_of_frame,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_green_level,
   output logic [7:0] rsp_red_level,
   output logic [7:0] rsp_blue_level,
   output logic       rsp_frame_done,
   input  logic       csr_wr_en,
   input  logic [1:0] csr_wr_data
);

   ltfr_pkg::cmd_type cmd;
   logic              trail_any_valid;
   logic              accept_req;
   logic              accept_clear;
   logic              accept_render;
   logic              accept_push;

   ltfr_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_type         (req_type),
      .req_end_of_frame (req_end_of_frame),
      .req_ready        (req_ready),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .cmd              (cmd)
   );

   ltfr_datapath #(
      .TRAIL_DEPTH (TRAIL_DEPTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_pixel_index  (req_pixel_index),
      .req_dot_index    (req_dot_index),
      .req_end_of_frame (req_end_of_frame),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .rsp_green_level  (rsp_green_level),
      .rsp_red_level    (rsp_red_level),
      .rsp_blue_level   (rsp_blue_level),
      .rsp_frame_done   (rsp_frame_done),
      .trail_any_valid  (trail_any_valid)
   );

   // Decode accepted request transactions for the checks
   assign accept_req    = req_valid && req_ready;
   assign accept_clear  = accept_req && (req_type == ltfr_pkg::ReqClear);
   assign accept_render = accept_req && (req_type == ltfr_pkg::ReqRender);
   assign accept_push   = accept_render && req_end_of_frame;

   // Check history, result and ready behavior
   `LTFR_ASSERT_NEXT(a_clear_empties, clock, reset, accept_clear, !trail_any_valid)
   `LTFR_ASSERT_NEXT(a_push_fills, clock, reset, accept_push, trail_any_valid)
   `LTFR_ASSERT_NEXT(a_render_valid, clock, reset, accept_render, rsp_valid)
   `LTFR_ASSERT_NEXT(a_done, clock, reset, accept_render, rsp_frame_done == $past(req_end_of_frame))
   `LTFR_ASSERT_SAME(a_ready_rule, clock, reset, 1'b1, req_ready == (!rsp_valid || rsp_ready))

endmodule

// ===== rtl/core/ltfr_ctrl.sv =====
// Controller: output register occupancy, handshakes and datapath commands.
module ltfr_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_type,
   input  logic               req_end_of_frame,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output ltfr_pkg::cmd_type  cmd
);

   ltfr_pkg::state_type state_ff;
   ltfr_pkg::state_type state_in;
   logic                accept_render;

   // Drive handshake status and commands
   always_comb begin
      req_ready     = (state_ff == ltfr_pkg::StEmpty) || rsp_ready;
      rsp_valid     = (state_ff == ltfr_pkg::StFull);
      accept_render = req_valid && req_ready && (req_type == ltfr_pkg::ReqRender);
      cmd.load_result = accept_render;
      cmd.push_trail  = accept_render && req_end_of_frame;
      cmd.clear_trail = req_valid && req_ready && (req_type == ltfr_pkg::ReqClear);
   end

   // Advance occupancy of the output register
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ltfr_pkg::StEmpty: begin
            if (accept_render) state_in = ltfr_pkg::StFull;
         end
         ltfr_pkg::StFull: begin
            if (rsp_ready && !accept_render) state_in = ltfr_pkg::StEmpty;
         end
         default: state_in = ltfr_pkg::StEmpty;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ltfr_pkg::StEmpty;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/core/ltfr_datapath.sv =====
// Datapath: trail history, per-slot match, color mapping and result register.
module ltfr_datapath #(
   parameter int TRAIL_DEPTH = 12
) (
   input  logic              clock,
   input  logic              reset,
   input  ltfr_pkg::cmd_type cmd,
   input  logic [7:0]        req_pixel_index,
   input  logic [7:0]        req_dot_index,
   input  logic              req_end_of_frame,
   input  logic              csr_wr_en,
   input  logic [1:0]        csr_wr_data,
   output logic [7:0]        rsp_green_level,
   output logic [7:0]        rsp_red_level,
   output logic [7:0]        rsp_blue_level,
   output logic              rsp_frame_done,
   output logic              trail_any_valid
);

   localparam int TrailStep = ltfr_pkg::LevelTrailTop / TRAIL_DEPTH;

   logic [7:0]             trail_pos_ff [TRAIL_DEPTH];
   logic [TRAIL_DEPTH-1:0] trail_valid_ff;
   logic [1:0]             color_mode_ff;
   logic [7:0]             green_ff;
   logic [7:0]             red_ff;
   logic [7:0]             blue_ff;
   logic                   frame_done_ff;
   logic [7:0]             level;
   logic [7:0]             dim;
   logic [7:0]             green_in;
   logic [7:0]             red_in;
   logic [7:0]             blue_in;

   // Match pixel against the dot and the history, newest slot winning
   always_comb begin
      level = 8'd0;
      for (int k = TRAIL_DEPTH - 1; k >= 0; k--) begin
         if (trail_valid_ff[k] && (trail_pos_ff[k] == req_pixel_index)) begin
            level = ltfr_pkg::trail_slot_level(k, TrailStep);
         end
      end
      if (req_pixel_index == req_dot_index) level = ltfr_pkg::LevelDot;
      dim = level >> ltfr_pkg::DimShift;
   end

   // Map level onto the bright channel, dim the others
   always_comb begin
      green_in = dim;
      red_in   = dim;
      blue_in  = dim;
      case (color_mode_ff)
         ltfr_pkg::ColorGreen: green_in = level;
         ltfr_pkg::ColorRed:   red_in   = level;
         ltfr_pkg::ColorBlue:  blue_in  = level;
         default: ;
      endcase
   end

   // Hold the color mode register
   always_ff @(posedge clock) begin
      if (reset) begin
         color_mode_ff <= ltfr_pkg::ColorReset;
      end else if (csr_wr_en) begin
         color_mode_ff <= csr_wr_data;
      end
   end

   // Shift valid marks on push, drop them all on clear
   always_ff @(posedge clock) begin
      if (reset || cmd.clear_trail) begin
         trail_valid_ff <= '0;
      end else if (cmd.push_trail) begin
         for (int k = TRAIL_DEPTH - 1; k > 0; k--) begin
            trail_valid_ff[k] <= trail_valid_ff[k-1];
         end
         trail_valid_ff[0] <= 1'b1;
      end
   end

   // Shift positions on push
   always_ff @(posedge clock) begin
      if (cmd.push_trail) begin
         for (int k = TRAIL_DEPTH - 1; k > 0; k--) begin
            trail_pos_ff[k] <= trail_pos_ff[k-1];
         end
         trail_pos_ff[0] <= req_dot_index;
      end
   end

   // Capture the result transaction
   always_ff @(posedge clock) begin
      if (cmd.load_result) begin
         green_ff      <= green_in;
         red_ff        <= red_in;
         blue_ff       <= blue_in;
         frame_done_ff <= req_end_of_frame;
      end
   end

   assign rsp_green_level = green_ff;
   assign rsp_red_level   = red_ff;
   assign rsp_blue_level  = blue_ff;
   assign rsp_frame_done  = frame_done_ff;
   assign trail_any_valid = |trail_valid_ff;

endmodule

// ===== bench/tb_top.sv =====
// Self-checking testbench for the LED trail fade renderer: directed table, then random frames.
`timescale 1ns / 100ps

module tb_top;

   localparam int         TrailDepth = 12;
   localparam logic [1:0] ColorNone  = 2'd3;   // no bright channel, all three dimmed
   localparam int         MaxGap     = 18;
   localparam int         CycleLimit = 400000;
   localparam int         PhaseItems = 190;
   localparam int         DrainPause = 4;

   typedef struct packed {
      logic [7:0] green;
      logic [7:0] red;
      logic [7:0] blue;
      logic       done;
   } pixel_out_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] pix;
      logic [7:0] dot;
      logic       eof;
      logic       typed;
      logic [7:0] green;
      logic [7:0] red;
      logic [7:0] blue;
   } drive_row_type;

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic       req_type;
   logic [7:0] req_pixel_index;
   logic [7:0] req_dot_index;
   logic       req_end_of_frame;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [7:0] rsp_green_level;
   logic [7:0] rsp_red_level;
   logic [7:0] rsp_blue_level;
   logic       rsp_frame_done;
   logic       csr_wr_en;
   logic [1:0] csr_wr_data;

   // Shadow copy of the trail history and bright-channel register
   logic [7:0]            trail_pos [TrailDepth];
   logic [TrailDepth-1:0] trail_live;
   logic [1:0]            bright_sel;

   pixel_out_type expected_pixels [$];
   pixel_out_type want_px;
   drive_row_type plan [$];
   int            mismatches = 0;
   int            cycle_count = 0;
   bit            req_calm = 1'b0;
   bit            rsp_calm = 1'b0;

   led_trail_fade_renderer #(.TRAIL_DEPTH(TrailDepth)) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_pixel_index  (req_pixel_index),
      .req_dot_index    (req_dot_index),
      .req_end_of_frame (req_end_of_frame),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_green_level  (rsp_green_level),
      .rsp_red_level    (rsp_red_level),
      .rsp_blue_level   (rsp_blue_level),
      .rsp_frame_done   (rsp_frame_done),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Bound the run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("status: fail");
         $finish;
      end
   end

   // Work out the color triple of one pixel from the current history
   function automatic pixel_out_type shade_pixel(logic [7:0] pix, logic [7:0] dot, logic eof);
      pixel_out_type px;
      int            fade_step;
      int            lvl;
      int            hit;
      logic [7:0]    lvl8;
      logic [7:0]    dim;
      fade_step = ltfr_pkg::LevelTrailTop / TrailDepth;
      lvl = ltfr_pkg::LevelTrailTop;
      hit = 0;
      if (pix == dot) begin
         lvl8 = ltfr_pkg::LevelDot;
      end else begin
         lvl8 = 8'd0;
         for (int k = 0; k < TrailDepth; k++) begin
            if (!hit && trail_live[k] && trail_pos[k] == pix) begin
               lvl8 = 8'(lvl);
               hit = 1;
            end
            lvl = (lvl >= fade_step) ? lvl - fade_step : 0;
         end
      end
      dim = lvl8 >> ltfr_pkg::DimShift;
      px.green = (bright_sel == ltfr_pkg::ColorGreen) ? lvl8 : dim;
      px.red   = (bright_sel == ltfr_pkg::ColorRed)   ? lvl8 : dim;
      px.blue  = (bright_sel == ltfr_pkg::ColorBlue)  ? lvl8 : dim;
      px.done  = eof;
      return px;
   endfunction

   function automatic drive_row_type make_row(logic kind, logic [7:0] pix, logic [7:0] dot,
                                              logic eof, logic typed, logic [7:0] green,
                                              logic [7:0] red, logic [7:0] blue);
      drive_row_type row;
      row.kind  = kind;
      row.pix   = pix;
      row.dot   = dot;
      row.eof   = eof;
      row.typed = typed;
      row.green = green;
      row.red   = red;
      row.blue  = blue;
      return row;
   endfunction

   function automatic int draw_gap(bit calm);
      return calm ? 0 : $urandom_range(0, MaxGap);
   endfunction

   // Apply an accepted transaction to the shadow state and queue its result
   task automatic note_accepted(drive_row_type row);
      pixel_out_type px;
      if (row.kind == ltfr_pkg::ReqClear) begin
         trail_live = '0;
      end else begin
         px = shade_pixel(row.pix, row.dot, row.eof);
         if (row.typed) begin
            px.green = row.green;
            px.red   = row.red;
            px.blue  = row.blue;
         end
         expected_pixels.push_back(px);
         if (row.eof) begin
            for (int k = TrailDepth - 1; k > 0; k--) begin
               trail_pos[k]  = trail_pos[k-1];
               trail_live[k] = trail_live[k-1];
            end
            trail_pos[0]  = row.dot;
            trail_live[0] = 1'b1;
         end
      end
   endtask

   // Drive one request transaction and hold it until accepted
   task automatic send(drive_row_type row);
      int gap;
      if ($urandom_range(0, 59) == 0) req_calm = !req_calm;
      gap = draw_gap(req_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_type         <= row.kind;
      req_pixel_index  <= row.pix;
      req_dot_index    <= row.dot;
      req_end_of_frame <= row.eof;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      note_accepted(row);
   endtask

   // Drain outstanding results, then write the bright-channel register
   task automatic set_bright(logic [1:0] mode);
      req_valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (DrainPause) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= mode;
      @(posedge clock);
      csr_wr_en  <= 1'b0;
      bright_sel = mode;
   endtask

   // Random frames: a dot bouncing over a short strip, with noise and broken frames
   task automatic run_frames(int quota);
      int         sent;
      int         len;
      int         base;
      int         dpos;
      int         dir;
      logic [7:0] pix;
      logic [7:0] dot;
      logic       eof;
      sent = 0;
      len  = $urandom_range(4, 32);
      base = $urandom_range(0, 256 - len);
      dpos = $urandom_range(0, len - 1);
      dir  = 1;
      while (sent < quota) begin
         if ($urandom_range(0, 39) == 0)
            send(make_row(ltfr_pkg::ReqClear,
                          8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)), 1'b0, 8'd0, 8'd0, 8'd0));
         // advance the dot, sometimes jumping
         if ($urandom_range(0, 15) == 0) begin
            dpos = $urandom_range(0, len - 1);
         end else begin
            if (dpos == len - 1) dir = -1;
            else if (dpos == 0) dir = 1;
            dpos += dir;
         end
         for (int p = 0; p < len; p++) begin
            pix = 8'(base + p);
            dot = 8'(base + dpos);
            if ($urandom_range(0, 15) == 0) pix = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 31) == 0) dot = 8'($urandom_range(0, 255));
            eof = (p == len - 1) || ($urandom_range(0, 49) == 0);
            send(make_row(ltfr_pkg::ReqRender, pix, dot, eof, 1'b0, 8'd0, 8'd0, 8'd0));
            sent++;
            if (eof) break;
         end
      end
   endtask

   // Result side: random stalls, then hold ready until a transaction completes
   initial begin
      int gap;
      rsp_ready = 1'b0;
      @(negedge reset);
      @(posedge clock);
      forever begin
         if ($urandom_range(0, 59) == 0) rsp_calm = !rsp_calm;
         gap = draw_gap(rsp_calm);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   // Compare each completed result with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_pixels.size() == 0) begin
            $display("%0t: unexpected result expected none actual %0d/%0d/%0d/%0d", $time,
                     rsp_green_level, rsp_red_level, rsp_blue_level, rsp_frame_done);
            mismatches++;
         end else begin
            want_px = expected_pixels.pop_front();
            check_field("green_level", want_px.green, rsp_green_level);
            check_field("red_level", want_px.red, rsp_red_level);
            check_field("blue_level", want_px.blue, rsp_blue_level);
            check_field("frame_done", 8'(want_px.done), 8'(rsp_frame_done));
         end
      end
   end

   // Main sequence
   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_type         = ltfr_pkg::ReqRender;
      req_pixel_index  = 8'd0;
      req_dot_index    = 8'd0;
      req_end_of_frame = 1'b0;
      csr_wr_en        = 1'b0;
      csr_wr_data      = ltfr_pkg::ColorReset;
      trail_live       = '0;
      bright_sel       = ltfr_pkg::ColorReset;
      for (int k = 0; k < TrailDepth; k++) trail_pos[k] = 8'd0;

      // Directed table, red mode out of reset
      plan.push_back(make_row(ltfr_pkg::ReqRender, 8'd0, 8'd0, 1'b0, 1'b1,
                              8'd31, 8'd255, 8'd31));
      plan.push_back(make_row(ltfr_pkg::ReqRender, 8'd254, 8'd0, 1'b0, 1'b1,
                              8'd0, 8'd0, 8'd0));
      plan.push_back(make_row(ltfr_pkg::ReqRender, 8'd255, 8'd255, 1'b0, 1'b1,
                              8'd31, 8'd255, 8'd31));
      // position 255 never matches an empty history
      plan.push_back(make_row(ltfr_pkg::ReqRender, 8'd255, 8'd10, 1'b0, 1'b1,
                              8'd0, 8'd0, 8'd0));
      plan.push_back(make_row(ltfr_pkg::ReqRender, 8'd5, 8'd5, 1'b1, 1'b1,
                              8'd31, 8'd255, 8'd31));
      plan.push_back(make_row(ltfr_pkg::ReqRender, 8'd5, 8'd9, 1'b0, 1'b1,
                              8'd25, 8'd200, 8'd25));
      // clear ignores its other fields
      plan.push_back(make_row(ltfr_pkg::ReqClear, 8'd5, 8'd5, 1'b1, 1'b0,
                              8'd0, 8'd0, 8'd0));
      plan.push_back(make_row(ltfr_pkg::ReqRender, 8'd5, 8'd9, 1'b0, 1'b1,
                              8'd0, 8'd0, 8'd0));
      plan.push_back(make_row(ltfr_pkg::ReqRender, 8'd0, 8'd255, 1'b1, 1'b1,
                              8'd0, 8'd0, 8'd0));
      // fill the history so that 255 reaches the oldest slot
      for (int d = 1; d <= TrailDepth - 1; d++)
         plan.push_back(make_row(ltfr_pkg::ReqRender, 8'd255, 8'(d), 1'b1, 1'b0,
                                 8'd0, 8'd0, 8'd0));
      plan.push_back(make_row(ltfr_pkg::ReqRender, 8'd255, 8'd0, 1'b0, 1'b0,
                              8'd0, 8'd0, 8'd0));
      // push once more: the oldest slot drops out
      plan.push_back(make_row(ltfr_pkg::ReqRender, 8'd250, 8'd12, 1'b1, 1'b0,
                              8'd0, 8'd0, 8'd0));
      plan.push_back(make_row(ltfr_pkg::ReqRender, 8'd255, 8'd0, 1'b0, 1'b1,
                              8'd0, 8'd0, 8'd0));
      plan.push_back(make_row(ltfr_pkg::ReqRender, 8'd1, 8'd0, 1'b0, 1'b0,
                              8'd0, 8'd0, 8'd0));

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      foreach (plan[i]) send(plan[i]);

      // Random phases across every bright-channel setting
      set_bright(ltfr_pkg::ColorGreen);
      run_frames(PhaseItems);
      set_bright(ltfr_pkg::ColorBlue);
      run_frames(PhaseItems);
      set_bright(ColorNone);
      run_frames(PhaseItems);
      set_bright(ltfr_pkg::ColorRed);
      run_frames(PhaseItems);
      set_bright(ltfr_pkg::ColorGreen);
      run_frames(PhaseItems);
      set_bright(ColorNone);
      run_frames(PhaseItems);
      set_bright(ltfr_pkg::ColorBlue);
      run_frames(PhaseItems);

      // Drain and finish
      req_valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (DrainPause) @(posedge clock);
      if (mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
